@@ src/sparse_vector_store_macros.svh @@
// ----------------------------------------------------------------------------
// sparse vector store assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SPARSE_VECTOR_STORE_MACROS_SVH
`define SPARSE_VECTOR_STORE_MACROS_SVH

// same-cycle implication
`define SVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svs assertion failed");

// next-cycle implication
`define SVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svs assertion failed");

`endif

@@ src/svs_pkg.sv @@
// ----------------------------------------------------------------------------
// svs_pkg
// constants, codes and types shared by the sparse vector store
// ----------------------------------------------------------------------------
`default_nettype none

package svs_pkg;

  localparam int CAPACITY   = 64;
  localparam int INDEX_BITS = 16;
  localparam int LEN_BITS   = INDEX_BITS + 1;
  localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam logic [LEN_BITS-1:0] LEN_RESET = {1'b1, {INDEX_BITS{1'b0}}};

  localparam logic [63:0] QNAN_BITS   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  // magnitude bits of 1e-30
  localparam logic [62:0] TINY_MAG    = 63'h39B4_484B_FEEB_C2A0;

  typedef enum logic [2:0] {
    OP_GET   = 3'd0,
    OP_SET   = 3'd1,
    OP_INC   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_NEG   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOR  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_ADD,
    S_RESP
  } svs_state_t;

  typedef enum logic [2:0] {
    FA_IDLE,
    FA_ALIGN,
    FA_ADD,
    FA_NORM,
    FA_ROUND
  } fa_state_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [63:0]           val;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic neg;
    logic we;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/svs_req_if.sv @@
// ----------------------------------------------------------------------------
// svs_req_if
// request channel: operation, index and value
// ----------------------------------------------------------------------------
`default_nettype none

interface svs_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic [svs_pkg::INDEX_BITS-1:0] index;
  logic [63:0]                   value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

`default_nettype wire

@@ src/svs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// svs_rsp_if
// response channel: read value and status
// ----------------------------------------------------------------------------
`default_nettype none

interface svs_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

@@ src/svs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// svs_cfg_if
// configuration write channel for the vector length
// ----------------------------------------------------------------------------
`default_nettype none

interface svs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [svs_pkg::LEN_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/svs_cell.sv @@
// ----------------------------------------------------------------------------
// svs_cell
// one table slot of the ring: holds an index/value pair, passes it on
// ----------------------------------------------------------------------------
`default_nettype none

module svs_cell (
  input  wire logic                clk,
  input  wire svs_pkg::cell_ctrl_t ctrl,
  input  wire svs_pkg::entry_t     din,
  input  wire svs_pkg::entry_t     nbr,
  output svs_pkg::entry_t          q
);

  // write, rotate or sign flip
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      q <= din;
    end else if (ctrl.shift) begin
      q <= nbr;
    end else if (ctrl.neg) begin
      q.val <= {~q.val[63], q.val[62:0]};
    end
  end

endmodule

`default_nettype wire

@@ src/svs_fadd.sv @@
// ----------------------------------------------------------------------------
// svs_fadd
// multi-cycle binary64 adder, round to nearest even, one-bit normalise steps
// ----------------------------------------------------------------------------
`default_nettype none

module svs_fadd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      sum
);

  svs_pkg::fa_state_t state, state_next;

  logic        spec;
  logic [63:0] sres;
  logic        sub, rsign, zsign;
  logic [11:0] ex;
  logic [11:0] shamt;
  logic [52:0] bsig, ssig;
  logic [55:0] smv;
  logic [56:0] r;

  // unpack terms
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic [63:0] bg, sm;
  // align terms
  logic [111:0] tmp;
  logic         sticky;
  // round terms
  logic         up;
  logic [53:0]  m54;
  logic [52:0]  mant;
  logic [11:0]  e2;

  always_comb begin
    a_nan = (&a[62:52]) && (|a[51:0]);
    b_nan = (&b[62:52]) && (|b[51:0]);
    a_inf = (&a[62:52]) && !(|a[51:0]);
    b_inf = (&b[62:52]) && !(|b[51:0]);
    a_big = a[62:0] >= b[62:0];
    bg    = a_big ? a : b;
    sm    = a_big ? b : a;
  end

  always_comb begin
    tmp    = {ssig, 3'b000, 56'd0} >> shamt;
    sticky = (shamt > 12'd55) ? (|ssig) : (|tmp[55:0]);
  end

  always_comb begin
    up  = r[2] & (r[1] | r[0] | r[3]);
    m54 = {1'b0, r[55:3]} + {53'd0, up};
    if (m54[53]) begin
      mant = m54[53:1];
      e2   = ex + 12'd1;
    end else begin
      mant = m54[52:0];
      e2   = ex;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      svs_pkg::FA_IDLE:  if (start) state_next = svs_pkg::FA_ALIGN;
      svs_pkg::FA_ALIGN: state_next = svs_pkg::FA_ADD;
      svs_pkg::FA_ADD:   state_next = svs_pkg::FA_NORM;
      svs_pkg::FA_NORM: begin
        if (spec || r == 57'd0) begin
          state_next = svs_pkg::FA_IDLE;
        end else if (r[56] || r[55] || ex <= 12'd1) begin
          state_next = svs_pkg::FA_ROUND;
        end
      end
      svs_pkg::FA_ROUND: state_next = svs_pkg::FA_IDLE;
      default:           state_next = svs_pkg::FA_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svs_pkg::FA_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == svs_pkg::FA_ROUND) ||
               (state == svs_pkg::FA_NORM && (spec || r == 57'd0));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      svs_pkg::FA_IDLE: begin
        if (start) begin
          spec  <= a_nan || b_nan || a_inf || b_inf;
          if (a_nan) begin
            sres <= {a[63:52], 1'b1, a[50:0]};
          end else if (b_nan) begin
            sres <= {b[63:52], 1'b1, b[50:0]};
          end else if (a_inf && b_inf && (a[63] != b[63])) begin
            sres <= svs_pkg::DEFAULT_NAN;
          end else if (a_inf) begin
            sres <= a;
          end else begin
            sres <= b;
          end
          ex    <= (bg[62:52] == 11'd0) ? 12'd1 : {1'b0, bg[62:52]};
          shamt <= ((bg[62:52] == 11'd0) ? 12'd1 : {1'b0, bg[62:52]}) -
                   ((sm[62:52] == 11'd0) ? 12'd1 : {1'b0, sm[62:52]});
          bsig  <= {|bg[62:52], bg[51:0]};
          ssig  <= {|sm[62:52], sm[51:0]};
          sub   <= a[63] ^ b[63];
          rsign <= bg[63];
          zsign <= a[63] & b[63];
        end
      end
      svs_pkg::FA_ALIGN: begin
        smv <= tmp[111:56] | {55'd0, sticky};
      end
      svs_pkg::FA_ADD: begin
        r <= sub ? ({1'b0, bsig, 3'b000} - {1'b0, smv})
                 : ({1'b0, bsig, 3'b000} + {1'b0, smv});
      end
      svs_pkg::FA_NORM: begin
        if (spec) begin
          sum <= sres;
        end else if (r == 57'd0) begin
          sum <= {zsign, 63'd0};
        end else if (r[56]) begin
          r  <= {1'b0, r[56:2], r[1] | r[0]};
          ex <= ex + 12'd1;
        end else if (!r[55] && ex > 12'd1) begin
          r  <= {r[55:0], 1'b0};
          ex <= ex - 12'd1;
        end
      end
      svs_pkg::FA_ROUND: begin
        if (e2 >= 12'd2047) begin
          sum <= {rsign, 11'h7FF, 52'd0};
        end else begin
          sum <= {rsign, (mant[52] ? e2[10:0] : 11'd0), mant[51:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/sparse_vector_store.sv @@
// Get and set take one full turn of the cell ring to search the table
// before the response; an increment on a present index then runs the
// float adder, which normalises in one-bit steps; clear, negate, unused
// ops and out-of-range requests skip the search. One request is worked on
// at a time: a new request is taken only after the last one's response.
// Reset: vector length 65536, table empty; no clearing pass is run.
// ----------------------------------------------------------------------------
// sparse_vector_store
// index/value table held in a rotating ring of cells with a float adder
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_vector_store_macros.svh"

module sparse_vector_store (
  input  wire logic clk,
  input  wire logic rst,
  svs_req_if.sink   req,
  svs_rsp_if.source rsp,
  svs_cfg_if.sink   cfg
);

  svs_pkg::svs_state_t state, state_next;

  logic [svs_pkg::LEN_BITS-1:0]   len;
  logic [svs_pkg::COUNT_BITS-1:0] count;
  svs_pkg::op_t                   op_q;
  logic [svs_pkg::INDEX_BITS-1:0] idx_q;
  logic [63:0]                    val_q;
  logic [svs_pkg::SLOT_BITS-1:0]  k, slot;
  logic                           hit;
  logic [63:0]                    hval;
  logic [63:0]                    rd_q;
  svs_pkg::status_t               st_q;

  svs_pkg::entry_t     cell_q    [svs_pkg::CAPACITY];
  svs_pkg::cell_ctrl_t cell_ctrl [svs_pkg::CAPACITY];

  logic        accept, in_range, k_last, rsp_free, full, tiny, is_upd, append;
  logic        do_shift, do_neg, wr_en, fa_start, fa_done;
  logic [svs_pkg::SLOT_BITS-1:0] wr_slot;
  svs_pkg::entry_t               wr_entry;
  logic [63:0]                   fa_sum;

  assign cfg.ready = 1'b1;

  always_comb begin
    accept   = req.valid && req.ready;
    in_range = {1'b0, req.index} < len;
    k_last   = k == svs_pkg::SLOT_BITS'(svs_pkg::CAPACITY - 1);
    rsp_free = !rsp.valid || rsp.ready;
    full     = count == svs_pkg::COUNT_BITS'(svs_pkg::CAPACITY);
    tiny     = val_q[62:0] < svs_pkg::TINY_MAG;
    is_upd   = (op_q == svs_pkg::OP_SET) || (op_q == svs_pkg::OP_INC);
    append   = is_upd && !hit && !tiny && !full;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      svs_pkg::S_IDLE: begin
        if (accept) begin
          if (req.op <= svs_pkg::OP_INC && in_range) begin
            state_next = svs_pkg::S_SEARCH;
          end else begin
            state_next = svs_pkg::S_RESP;
          end
        end
      end
      svs_pkg::S_SEARCH: if (k_last) state_next = svs_pkg::S_DECIDE;
      svs_pkg::S_DECIDE: begin
        if (op_q == svs_pkg::OP_INC && hit) begin
          state_next = svs_pkg::S_ADD;
        end else begin
          state_next = svs_pkg::S_RESP;
        end
      end
      svs_pkg::S_ADD:  if (fa_done) state_next = svs_pkg::S_RESP;
      svs_pkg::S_RESP: if (rsp_free) state_next = svs_pkg::S_IDLE;
      default:         state_next = svs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = state == svs_pkg::S_IDLE;
    do_shift  = state == svs_pkg::S_SEARCH;
    do_neg    = state == svs_pkg::S_IDLE && accept && req.op == svs_pkg::OP_NEG;
    fa_start  = state == svs_pkg::S_DECIDE && op_q == svs_pkg::OP_INC && hit;
    wr_en     = 1'b0;
    wr_slot   = slot;
    wr_entry  = '{idx: idx_q, val: val_q};
    case (state)
      svs_pkg::S_DECIDE: begin
        if (op_q == svs_pkg::OP_SET && hit) begin
          wr_en = 1'b1;
        end else if (append) begin
          wr_en   = 1'b1;
          wr_slot = svs_pkg::SLOT_BITS'(count);
        end
      end
      svs_pkg::S_ADD: begin
        wr_en    = fa_done;
        wr_entry = '{idx: idx_q, val: fa_sum};
      end
      default: begin
      end
    endcase
  end

  // ring of table cells
  for (genvar i = 0; i < svs_pkg::CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i] = '{shift: do_shift, neg: do_neg,
                            we: wr_en && (wr_slot == svs_pkg::SLOT_BITS'(i))};
    svs_cell u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl[i]),
      .din  (wr_entry),
      .nbr  (cell_q[(i + 1) % svs_pkg::CAPACITY]),
      .q    (cell_q[i])
    );
  end

  // float adder for increment
  svs_fadd u_fadd (
    .clk   (clk),
    .rst   (rst),
    .start (fa_start),
    .a     (hval),
    .b     (val_q),
    .done  (fa_done),
    .sum   (fa_sum)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= svs_pkg::S_IDLE;
      len       <= svs_pkg::LEN_RESET;
      count     <= '0;
      hit       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) len <= cfg.data;
      if (state == svs_pkg::S_IDLE && accept) begin
        hit <= 1'b0;
        if (req.op == svs_pkg::OP_CLEAR) count <= '0;
      end
      if (state == svs_pkg::S_SEARCH && !hit &&
          svs_pkg::COUNT_BITS'(k) < count && cell_q[0].idx == idx_q) begin
        hit <= 1'b1;
      end
      if (state == svs_pkg::S_DECIDE && append) count <= count + 1'b1;
      if (state == svs_pkg::S_RESP && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state == svs_pkg::S_IDLE && accept) begin
      op_q  <= svs_pkg::op_t'(req.op);
      idx_q <= req.index;
      val_q <= req.value;
      k     <= '0;
      rd_q  <= '0;
      st_q  <= svs_pkg::STAT_OK;
      if (req.op <= svs_pkg::OP_INC && !in_range) begin
        st_q <= svs_pkg::STAT_OOR;
        if (req.op == svs_pkg::OP_GET) rd_q <= svs_pkg::QNAN_BITS;
      end
    end
    if (state == svs_pkg::S_SEARCH) begin
      k <= k + 1'b1;
      if (!hit && svs_pkg::COUNT_BITS'(k) < count && cell_q[0].idx == idx_q) begin
        slot <= k;
        hval <= cell_q[0].val;
      end
    end
    if (state == svs_pkg::S_DECIDE) begin
      rd_q <= (op_q == svs_pkg::OP_GET && hit) ? hval : 64'd0;
      st_q <= (is_upd && !hit && !tiny && full) ? svs_pkg::STAT_FULL
                                                 : svs_pkg::STAT_OK;
    end
    if (state == svs_pkg::S_RESP && rsp_free) begin
      rsp.read_value <= rd_q;
      rsp.status     <= st_q;
    end
  end

  `SVS_ASSERT_IMP(a_count_bound, 1'b1,
                  count <= svs_pkg::COUNT_BITS'(svs_pkg::CAPACITY))
  `SVS_ASSERT_IMP(a_add_done_in_add, fa_done, state == svs_pkg::S_ADD)
  `SVS_ASSERT_NXT(a_search_runs, state == svs_pkg::S_SEARCH && !k_last,
                  state == svs_pkg::S_SEARCH)
  `SVS_ASSERT_NXT(a_decide_exit, state == svs_pkg::S_DECIDE,
                  state == svs_pkg::S_ADD || state == svs_pkg::S_RESP)

endmodule

`default_nettype wire

@@ tb/sv/sparse_vector_store_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_vector_store_checker
// watches the request, response and length channels of the sparse vector
// store, keeps its own copy of the entry table, predicts each response and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_vector_store_checker (
  input  wire logic clk,
  input  wire logic rst,
  svs_req_if        req,
  svs_rsp_if        rsp,
  svs_cfg_if        cfg,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic [63:0]      read_value;
    svs_pkg::status_t status;
  } response_t;

  logic [svs_pkg::LEN_BITS-1:0]   length;
  logic [svs_pkg::INDEX_BITS-1:0] stored_index [svs_pkg::CAPACITY];
  logic [63:0]                    stored_value [svs_pkg::CAPACITY];
  int                             stored_count;
  response_t                      awaited [$];

  function automatic bit is_nan(logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != 0);
  endfunction

  // double add with the usual nan rules: first nan operand wins, quietened
  function automatic logic [63:0] double_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    if (is_nan(a)) return a | 64'h0008_0000_0000_0000;
    if (is_nan(b)) return b | 64'h0008_0000_0000_0000;
    s = $realtobits($bitstoreal(a) + $bitstoreal(b));
    if (is_nan(s)) return svs_pkg::DEFAULT_NAN;
    return s;
  endfunction

  // work out the response to one request and update the table
  function automatic response_t apply_request(logic [2:0] op,
                                              logic [svs_pkg::INDEX_BITS-1:0] idx,
                                              logic [63:0] val);
    response_t r;
    int slot;
    r.read_value = '0;
    r.status     = svs_pkg::STAT_OK;
    slot         = -1;
    if (op == svs_pkg::OP_GET || op == svs_pkg::OP_SET || op == svs_pkg::OP_INC) begin
      if ({1'b0, idx} >= length) begin
        r.status = svs_pkg::STAT_OOR;
        if (op == svs_pkg::OP_GET) r.read_value = svs_pkg::QNAN_BITS;
      end else begin
        for (int j = stored_count - 1; j >= 0; j--)
          if (stored_index[j] == idx) slot = j;
        if (op == svs_pkg::OP_GET) begin
          if (slot >= 0) r.read_value = stored_value[slot];
        end else if (slot >= 0) begin
          stored_value[slot] = (op == svs_pkg::OP_SET) ? val
                                              : double_sum(stored_value[slot], val);
        end else if (!(val[62:0] < svs_pkg::TINY_MAG)) begin
          if (stored_count >= svs_pkg::CAPACITY) begin
            r.status = svs_pkg::STAT_FULL;
          end else begin
            stored_index[stored_count] = idx;
            stored_value[stored_count] = val;
            stored_count++;
          end
        end
      end
    end else if (op == svs_pkg::OP_CLEAR) begin
      stored_count = 0;
    end else if (op == svs_pkg::OP_NEG) begin
      for (int j = 0; j < stored_count; j++) stored_value[j][63] = ~stored_value[j][63];
    end
    return r;
  endfunction

  // compare responses, then record new requests and length writes
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      length       = svs_pkg::LEN_RESET;
      stored_count = 0;
      awaited.delete();
      fail_count   = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited.push_back(apply_request(req.op, req.index, req.value));
      if (cfg.valid && cfg.ready) length = cfg.data;
    end
    pending = awaited.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/sparse_vector_store_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_vector_store_tb
// drives get, set, increment, clear and negate requests at several vector
// lengths with random idling on both sides; the checker judges responses
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_vector_store_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 195;
  localparam int PHASES      = 9;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  int   tx_gap_pct;
  int   rx_stall_pct;

  svs_req_if req ();
  svs_rsp_if rsp ();
  svs_cfg_if cfg ();

  sparse_vector_store i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  sparse_vector_store_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // response side stalls
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one request, with random gaps before it
  task automatic send_request(svs_pkg::op_t op, logic [svs_pkg::INDEX_BITS-1:0] idx,
                              logic [63:0] val);
    while ($urandom_range(99) < tx_gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.index <= idx;
    req.value <= val;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    sent++;
    if (sent < 616) begin
      tx_gap_pct = 21; rx_stall_pct = 59;
    end else if (sent < 1232) begin
      tx_gap_pct = 59; rx_stall_pct = 21;
    end else begin
      tx_gap_pct = 0; rx_stall_pct = 0;
    end
  endtask

  // length write once every response is in
  task automatic write_length(logic [svs_pkg::LEN_BITS-1:0] len);
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= len;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $realtobits(real'($urandom_range(200)) / 4.0 - 25.0);
      4, 5:       v = {$urandom, $urandom};
      6:          v = {1'($urandom), 11'($urandom_range(11'h39A)), 20'($urandom), $urandom};
      7:          v = {1'($urandom), 11'h39B, 52'h4_484B_FEEB_C2A0 - 52'($urandom_range(1))};
      8:          v = {1'($urandom), 11'h7FF, 20'($urandom), $urandom};
      default: begin
        case ($urandom_range(4))
          0: v = 64'h0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FF0_0000_0000_0000;
          3: v = 64'hFFF0_0000_0000_0000;
          default: v = 64'h7FEF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [svs_pkg::INDEX_BITS-1:0] pick_index(
      logic [svs_pkg::LEN_BITS-1:0] len);
    case ($urandom_range(9))
      0, 1:    return svs_pkg::INDEX_BITS'($urandom);
      2:       return svs_pkg::INDEX_BITS'(len - 17'($urandom_range(2)));
      default: return svs_pkg::INDEX_BITS'($urandom_range(79));
    endcase
  endfunction

  function automatic svs_pkg::op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return svs_pkg::OP_GET;
    if (r < 58) return svs_pkg::OP_SET;
    if (r < 88) return svs_pkg::OP_INC;
    if (r < 89) return svs_pkg::OP_CLEAR;
    if (r < 96) return svs_pkg::OP_NEG;
    return svs_pkg::op_t'(3'($urandom_range(7, 5)));
  endfunction

  initial begin
    logic [svs_pkg::LEN_BITS-1:0] lengths [PHASES];
    lengths = '{17'd65536, 17'd100, 17'd1, 17'd0, 17'd65535,
                17'h1FFFF, 17'd40, 17'd65536, 17'd3000};
    rst          = 1'b1;
    cycles       = 0;
    sent         = 0;
    tx_gap_pct   = 21;
    rx_stall_pct = 59;
    req.valid    = 1'b0;
    req.op       = svs_pkg::OP_GET;
    req.index    = '0;
    req.value    = '0;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    rsp.ready    = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: empty get, set, add, tiny, nan, negate, unused ops, bounds
    send_request(svs_pkg::OP_GET, 16'd5, 64'h0);
    send_request(svs_pkg::OP_SET, 16'd5, $realtobits(1.5));
    send_request(svs_pkg::OP_GET, 16'd5, 64'h0);
    send_request(svs_pkg::OP_INC, 16'd5, $realtobits(2.25));
    send_request(svs_pkg::OP_GET, 16'd5, 64'h0);
    send_request(svs_pkg::OP_SET, 16'd7, $realtobits(1.0e-40));
    send_request(svs_pkg::OP_INC, 16'd7, 64'h8000_0000_0000_0001);
    send_request(svs_pkg::OP_GET, 16'd7, 64'h0);
    send_request(svs_pkg::OP_SET, 16'd8, 64'h7FF4_0000_0000_0001);
    send_request(svs_pkg::OP_SET, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(svs_pkg::OP_NEG, 16'd0, 64'h0);
    send_request(svs_pkg::OP_GET, 16'd8, 64'h0);
    send_request(svs_pkg::OP_GET, 16'hFFFF, 64'h0);
    send_request(svs_pkg::OP_INC, 16'd5, $realtobits(3.75));
    send_request(svs_pkg::OP_GET, 16'd5, 64'h0);
    send_request(svs_pkg::op_t'(3'd5), 16'd5, 64'h1);
    send_request(svs_pkg::op_t'(3'd7), 16'd5, 64'h1);
    send_request(svs_pkg::OP_CLEAR, 16'd0, 64'h0);
    send_request(svs_pkg::OP_GET, 16'd5, 64'h0);
    write_length(17'd10);
    send_request(svs_pkg::OP_GET, 16'd10, 64'h0);
    send_request(svs_pkg::OP_SET, 16'd12, $realtobits(2.0));
    send_request(svs_pkg::OP_GET, 16'd9, 64'h0);

    // fill the table past its capacity
    write_length(17'd65536);
    for (int k = 0; k < svs_pkg::CAPACITY + 3; k++)
      send_request(svs_pkg::OP_SET, svs_pkg::INDEX_BITS'(k * 3),
                   $realtobits(real'(k) + 0.5));
    send_request(svs_pkg::OP_INC, 16'd1, $realtobits(1.0));
    send_request(svs_pkg::OP_GET, 16'd3, 64'h0);
    send_request(svs_pkg::OP_CLEAR, 16'd0, 64'h0);

    // random phases at several lengths
    for (int p = 0; p < PHASES; p++) begin
      write_length(lengths[p]);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_request(pick_op(), pick_index(lengths[p]), pick_value());
    end

    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
